FILE: rtl/core/multichannel_pid_step_core_macros.svh
// Assertion macros shared by the PID step core.
`ifndef MULTICHANNEL_PID_STEP_CORE_MACROS_SVH
`define MULTICHANNEL_PID_STEP_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, muted while arst_n is low.
`define MPID_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pid core: same-cycle check failed");

// Next-cycle implication, checked on clk, muted while arst_n is low.
`define MPID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pid core: next-cycle check failed");

`endif

FILE: rtl/core/mpid_pkg.sv
// Constants, types and saturation helper for the multichannel PID step core.
`default_nettype none
package mpid_pkg;
	localparam int CHANNELS  = 8;
	localparam int FRAC_BITS = 16;
	localparam int CH_W      = 3;
	localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DATA_W    = 32;
	localparam int REG_W     = 31;
	localparam int OPA_W     = DATA_W + 1;
	localparam int PROD_W    = OPA_W + DATA_W;
	localparam int ACC_W     = 64;

	localparam logic [REG_W-1:0] TIME_STEP_RST     = 31'd6554;
	localparam logic [REG_W-1:0] INV_TIME_STEP_RST = 31'd655360;

	// Configuration register indexes
	localparam logic REG_TIME_STEP     = 1'b0;
	localparam logic REG_INV_TIME_STEP = 1'b1;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] val;
	} clip_t;

	// Clip a wide signed value to 32 bits; hit marks clipping.
	function automatic clip_t clip32(input logic signed [ACC_W-1:0] v);
		clip_t r;
		r.hit = 1'b0;
		r.val = $signed(v[DATA_W-1:0]);
		if (v > SAT_MAX) begin
			r.hit = 1'b1;
			r.val = $signed(SAT_MAX[DATA_W-1:0]);
		end else if (v < SAT_MIN) begin
			r.hit = 1'b1;
			r.val = $signed(SAT_MIN[DATA_W-1:0]);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/mpid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                          clk,
	input  wire logic                                          wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  wire logic [WIDTH-1:0]                              wr_data,
	input  wire logic                                          rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	output      logic [WIDTH-1:0]                              rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/multichannel_pid_step_core.sv
// Multichannel PID step: an accepted beat passes through MUL_I, MUL_D, MUL_P, MUL_KI, MUL_KD and DONE to out_valid.
// One item at a time, with one shared 33x32 multiplier used 5 times per item.
// The next item is taken while a finished result still waits in the output register.
// Reset: config registers return to defaults, per-channel valid bits clear so both
// stores read as zero; no clearing pass, the block is ready right after reset.
`default_nettype none
`include "multichannel_pid_step_core_macros.svh"
module multichannel_pid_step_core
	import mpid_pkg::*;
(
	input  wire  logic                     clk,
	input  wire  logic                     arst_n,
	// configuration write port
	input  wire  logic                     cfg_we,
	input  wire  logic                     cfg_index,
	input  wire  logic [REG_W-1:0]         cfg_data,
	// input channel
	input  wire  logic                     in_valid,
	output       logic                     in_stall,
	input  wire  logic [CH_W-1:0]          channel,
	input  wire  logic signed [DATA_W-1:0] target,
	input  wire  logic signed [DATA_W-1:0] measured,
	input  wire  logic signed [DATA_W-1:0] gain_p,
	input  wire  logic signed [DATA_W-1:0] gain_i,
	input  wire  logic signed [DATA_W-1:0] gain_d,
	// output channel
	output       logic                     out_valid,
	input  wire  logic                     out_stall,
	output       logic [CH_W-1:0]          out_channel,
	output       logic signed [DATA_W-1:0] drive,
	output       logic                     saturated
);
	// Sequencer codes. Each multiply state issues one multiply into prod_q; each
	// state after MUL_I consumes the product issued by the state before it.
	localparam logic [2:0] ST_IDLE   = 3'd0; // wait for a beat, read both stores
	localparam logic [2:0] ST_MUL_I  = 3'd1; // err * dt
	localparam logic [2:0] ST_MUL_D  = 3'd2; // finish integral, (err - last) * 1/dt
	localparam logic [2:0] ST_MUL_P  = 3'd3; // finish derivative, kp * err, write back
	localparam logic [2:0] ST_MUL_KI = 3'd4; // add P term, ki * integral
	localparam logic [2:0] ST_MUL_KD = 3'd5; // add I term, kd * derivative
	localparam logic [2:0] ST_DONE   = 3'd6; // add D term, clip, load output

	logic [2:0]               state_q;
	logic [REG_W-1:0]         ts_q;
	logic [REG_W-1:0]         its_q;
	logic [CHANNELS-1:0]      valid_q;

	logic [CH_W-1:0]          ch_q;
	logic                     in_range_q;
	logic                     vld_q;
	logic                     sat_q;
	logic signed [DATA_W-1:0] err_q;
	logic signed [DATA_W-1:0] kp_q;
	logic signed [DATA_W-1:0] ki_q;
	logic signed [DATA_W-1:0] kd_q;
	logic signed [DATA_W-1:0] integ_q;
	logic signed [DATA_W-1:0] deriv_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     out_valid_q;
	logic [CH_W-1:0]          out_channel_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     saturated_q;

	logic                     in_accept;
	logic                     out_free;
	logic                     in_rng;
	logic [CH_AW-1:0]         rd_addr;
	logic [CH_AW-1:0]         wr_addr;
	logic                     wr_en;
	logic [DATA_W-1:0]        integ_rd;
	logic [DATA_W-1:0]        last_rd;
	logic signed [DATA_W-1:0] integ_old;
	logic signed [DATA_W-1:0] last_err;
	logic signed [OPA_W-1:0]  mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]  term;
	clip_t                    err_c;
	clip_t                    integ_c;
	clip_t                    deriv_c;
	clip_t                    drive_c;

	// One item in flight; the output register decouples the result side.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign in_rng  = (32'(channel) < CHANNELS);
	assign rd_addr = CH_AW'(channel);
	assign wr_addr = CH_AW'(ch_q);
	assign wr_en   = (state_q == ST_MUL_P) && in_range_q;

	// Per-channel stores: integral and previous error
	mpid_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_integ_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (integ_q),
		.rd_en   (in_accept),
		.rd_addr (rd_addr),
		.rd_data (integ_rd)
	);

	mpid_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_err_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (err_q),
		.rd_en   (in_accept),
		.rd_addr (rd_addr),
		.rd_data (last_rd)
	);

	// An entry never written since reset reads as zero.
	assign integ_old = vld_q ? $signed(integ_rd) : '0;
	assign last_err  = vld_q ? $signed(last_rd) : '0;

	// Error is formed straight from the input ports in the accept cycle.
	assign err_c = clip32(ACC_W'(target) - ACC_W'(measured));

	// Shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MUL_I: begin
				mul_a = OPA_W'(err_q);
				mul_b = $signed({1'b0, ts_q});
			end
			ST_MUL_D: begin
				mul_a = OPA_W'(err_q) - OPA_W'(last_err);
				mul_b = $signed({1'b0, its_q});
			end
			ST_MUL_P: begin
				mul_a = OPA_W'(err_q);
				mul_b = kp_q;
			end
			ST_MUL_KI: begin
				mul_a = OPA_W'(integ_q);
				mul_b = ki_q;
			end
			ST_MUL_KD: begin
				mul_a = OPA_W'(deriv_q);
				mul_b = kd_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Floor shift of the previous product; the top bits are pure sign.
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign term    = $signed(prod_sh[ACC_W-1:0]);

	assign integ_c = clip32(ACC_W'(integ_old) + term);
	assign deriv_c = clip32(term);
	assign drive_c = clip32(acc_q + term);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= TIME_STEP_RST;
			its_q <= INV_TIME_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP:     ts_q  <= cfg_data;
				REG_INV_TIME_STEP: its_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and per-channel valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE:   if (in_accept) state_q <= ST_MUL_I;
				ST_MUL_I:  state_q <= ST_MUL_D;
				ST_MUL_D:  state_q <= ST_MUL_P;
				ST_MUL_P:  state_q <= ST_MUL_KI;
				ST_MUL_KI: state_q <= ST_MUL_KD;
				ST_MUL_KD: state_q <= ST_DONE;
				ST_DONE:   if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ch_q       <= channel;
			in_range_q <= in_rng;
			vld_q      <= in_rng && valid_q[rd_addr];
			err_q      <= err_c.val;
			sat_q      <= err_c.hit;
			kp_q       <= gain_p;
			ki_q       <= gain_i;
			kd_q       <= gain_d;
		end
		if (state_q != ST_IDLE && state_q != ST_DONE) begin
			prod_q <= mul_p;
		end
		case (state_q)
			ST_MUL_D: begin
				integ_q <= integ_c.val;
				sat_q   <= sat_q | integ_c.hit;
			end
			ST_MUL_P: begin
				deriv_q <= deriv_c.val;
				sat_q   <= sat_q | deriv_c.hit;
				acc_q   <= '0;
			end
			ST_MUL_KI, ST_MUL_KD: begin
				acc_q <= acc_q + term;
			end
			default: ;
		endcase
	end

	// Output register: load from DONE, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_channel_q <= ch_q;
			if (in_range_q) begin
				drive_q     <= drive_c.val;
				saturated_q <= sat_q | drive_c.hit;
			end else begin
				drive_q     <= '0;
				saturated_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign drive       = drive_q;
	assign saturated   = saturated_q;

	// A taken beat always starts the multiply sequence with the input side closed.
	`MPID_ASSERT_NEXT(a_accept_starts, in_accept, (state_q == ST_MUL_I) && in_stall)
	// A finished item waits in DONE while the output register is still stalled.
	`MPID_ASSERT_NEXT(a_done_holds, (state_q == ST_DONE) && out_valid && out_stall, state_q == ST_DONE)
	// New results come only out of the DONE state.
	`MPID_ASSERT_NOW(a_rise_from_done, $rose(out_valid), $past(state_q) == ST_DONE)
endmodule
`default_nettype wire
